// ----- hw/rtl/slrf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrf_pkg
// Shared widths, constants, register indexes, the sine table and helpers of
// the stereo resonant filter with LFO-modulated cutoff.
// ----------------------------------------------------------------------------
package slrf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC       = 16;
    localparam int STATE_W    = SAMPLE_W + FRAC + 8;
    localparam int PHASE_W    = 32;
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int SINE_W     = FRAC + 2;

    localparam int CO_W    = FRAC + 1;
    localparam int FB_W    = FRAC + 8;
    localparam int RECIP_W = FRAC + 8;
    localparam int MA_W    = 32;
    localparam int MB_W    = FRAC + 8;
    localparam int P_W     = MA_W + MB_W;
    localparam int V_W     = FRAC + 10;
    localparam int DIV_W   = 2 * FRAC + 1;

    localparam int CO_LO = ((1 << FRAC) + 50) / 100;
    localparam int CO_HI = ((99 << FRAC) + 50) / 100;

    localparam longint STATE_MAX = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;

    localparam int STEP_MUL = 1343944;
    localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESONANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LFO_RATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LFO_DEPTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LFO_OFS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd5;

    typedef struct packed {
        logic [7:0] cutoff;
        logic [7:0] resonance;
        logic [7:0] depth;
        logic       mode;
    } t_lane_cfg;

    typedef logic signed [SINE_W-1:0] t_sine_rom [SINE_DEPTH];

    // Quarter-wave Taylor series, evaluated once at elaboration.
    function automatic t_sine_rom build_sine();
        t_sine_rom         rom;
        logic [63:0]        quarter;
        logic [63:0]        rem;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        s;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            quarter = 64'(4 * i) / SINE_DEPTH;
            rem     = 64'(4 * i) - quarter * SINE_DEPTH;
            r       = quarter[0] ? 64'(SINE_DEPTH) - rem : rem;
            x       = (HALFPI_Q30 * r + 64'(SINE_DEPTH / 2)) / SINE_DEPTH;
            x2      = (x * x + (64'd1 << 29)) >> 30;
            term    = x;
            sum     = $signed(x);
            for (int k = 1; k <= 10; k++) begin
                term = (term * x2 + (64'd1 << 29)) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            s = ($unsigned(sum) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
            rom[i] = (quarter >= 2) ? -SINE_W'(s) : SINE_W'(s);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine();

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [STATE_W+1:0] v
    );
        logic signed [STATE_W-1:0] res;
        if (v > (STATE_W+2)'(STATE_MAX)) begin
            res = STATE_W'(STATE_MAX);
        end else if (v < -(STATE_W+2)'(STATE_MAX) - 1) begin
            res = -STATE_W'(STATE_MAX) - 1;
        end else begin
            res = v[STATE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/slrf_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrf_lane
// One channel: coefficient update from the LFO sine, reciprocal divider and
// the two-stage resonant filter, all on one shared 32x24 multiplier.
// ----------------------------------------------------------------------------
module slrf_lane (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_block_start,
    input  logic signed [slrf_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [slrf_pkg::PHASE_W-1:0]          i_phase,
    input  slrf_pkg::t_lane_cfg                   i_cfg,
    output logic                                  o_done,
    output logic signed [slrf_pkg::SAMPLE_W-1:0]  o_out
);

    localparam int SW   = slrf_pkg::STATE_W;
    localparam int F    = slrf_pkg::FRAC;
    localparam int SMW  = slrf_pkg::SAMPLE_W;
    localparam int HI_W = SW + 1 - 32;
    localparam int HP_W = HI_W + slrf_pkg::MB_W;
    localparam int SUM_W = SW + 1 + slrf_pkg::MB_W;
    localparam int CNT_W = $clog2(slrf_pkg::DIV_W + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROM   = 4'd1;
    localparam logic [3:0] S_SMUL  = 4'd2;
    localparam logic [3:0] S_CLAMP = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_FBMUL = 4'd5;
    localparam logic [3:0] S_FB    = 4'd6;
    localparam logic [3:0] S_ABS   = 4'd7;
    localparam logic [3:0] S_LO    = 4'd8;
    localparam logic [3:0] S_HI    = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    localparam logic [2:0] OP_FEED = 3'd0;  // u = x + (s1 - s2) * fb
    localparam logic [2:0] OP_S1FA = 3'd1;
    localparam logic [2:0] OP_UCO  = 3'd2;  // a = s1 * fa + u * co
    localparam logic [2:0] OP_S2FA = 3'd3;
    localparam logic [2:0] OP_ACO  = 3'd4;  // b = s2 * fa + a * co

    logic [3:0]                       r_state;
    logic [2:0]                       r_op;
    logic [CNT_W-1:0]                 r_cnt;
    logic [slrf_pkg::PHASE_W-1:0]     r_phase;
    logic signed [slrf_pkg::SINE_W-1:0] r_sine;
    logic [slrf_pkg::P_W-1:0]         r_prod;
    logic [slrf_pkg::P_W-1:0]         r_plo;
    logic [slrf_pkg::CO_W-1:0]        r_co;
    logic [slrf_pkg::CO_W-1:0]        r_fa;
    logic [slrf_pkg::FB_W-1:0]        r_fb;
    logic [F-1:0]                     r_rem;
    logic [slrf_pkg::DIV_W-1:0]       r_dnum;
    logic [slrf_pkg::RECIP_W-1:0]     r_quo;
    logic signed [SW-1:0]             r_x;
    logic signed [SW-1:0]             r_s1;
    logic signed [SW-1:0]             r_s2;
    logic signed [SW-1:0]             r_u;
    logic signed [SW-1:0]             r_t;
    logic signed [SW-1:0]             r_a;
    logic [SW:0]                      r_ua;
    logic                             r_neg;
    logic                             r_done;
    logic signed [SMW-1:0]            r_out;

    logic [slrf_pkg::MA_W-1:0]        m_a;
    logic [slrf_pkg::MB_W-1:0]        m_b;
    logic [slrf_pkg::MB_W-1:0]        op_b;
    logic signed [SW:0]               op_a;
    logic [slrf_pkg::SINE_W-2:0]      sine_mag;
    logic signed [slrf_pkg::V_W-1:0]  v_base;
    logic signed [slrf_pkg::V_W-1:0]  v_mod;
    logic signed [slrf_pkg::V_W-1:0]  v_clamp;
    logic [slrf_pkg::V_W-1:0]         v_round;
    logic [slrf_pkg::CO_W-1:0]        co_new;
    logic [slrf_pkg::CO_W-1:0]        fa_new;
    logic [F:0]                       rem_sh;
    logic                             q_bit;
    logic [SUM_W-1:0]                 mq_sum;
    logic [SUM_W-1:0]                 mq_rnd;
    logic [SW-1:0]                    mq_mag;
    logic signed [SW:0]               mq;
    logic signed [SW+1:0]             acc_sum;
    logic signed [SW:0]               y;
    logic signed [SW+1:0]             y_rnd;
    logic signed [SW+1:0]             o_full;
    logic signed [SMW:0]              smp1;

    assign smp1 = {i_sample[SMW-1], i_sample} + (SMW+1)'(1);

    // Operand selection for the filter multiplies.
    always_comb begin
        unique case (r_op)
            OP_FEED: begin
                op_a = {r_s1[SW-1], r_s1} - {r_s2[SW-1], r_s2};
                op_b = slrf_pkg::MB_W'(r_fb);
            end
            OP_S1FA: begin
                op_a = {r_s1[SW-1], r_s1};
                op_b = slrf_pkg::MB_W'(r_fa);
            end
            OP_UCO: begin
                op_a = {r_u[SW-1], r_u};
                op_b = slrf_pkg::MB_W'(r_co);
            end
            OP_S2FA: begin
                op_a = {r_s2[SW-1], r_s2};
                op_b = slrf_pkg::MB_W'(r_fa);
            end
            default: begin
                op_a = {r_a[SW-1], r_a};
                op_b = slrf_pkg::MB_W'(r_co);
            end
        endcase
    end

    assign sine_mag = r_sine[slrf_pkg::SINE_W-1] ? (slrf_pkg::SINE_W-1)'(-r_sine)
                                                  : (slrf_pkg::SINE_W-1)'(r_sine);

    always_comb begin
        unique case (r_state)
            S_SMUL: begin
                m_a = slrf_pkg::MA_W'(sine_mag);
                m_b = slrf_pkg::MB_W'(i_cfg.depth);
            end
            S_FBMUL: begin
                m_a = slrf_pkg::MA_W'(r_quo) + (slrf_pkg::MA_W'(1) << F);
                m_b = slrf_pkg::MB_W'(i_cfg.resonance);
            end
            S_LO: begin
                m_a = r_ua[31:0];
                m_b = op_b;
            end
            S_HI: begin
                m_a = slrf_pkg::MA_W'(r_ua[SW:32]);
                m_b = op_b;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // Cutoff: base plus sine times depth, clamped, rounded to Q.F.
    always_comb begin
        v_base = slrf_pkg::V_W'({i_cfg.cutoff, {F{1'b0}}});
        if (r_sine[slrf_pkg::SINE_W-1]) begin
            v_mod = v_base - slrf_pkg::V_W'(r_prod[F+7:0]);
        end else begin
            v_mod = v_base + slrf_pkg::V_W'(r_prod[F+7:0]);
        end
        if (v_mod < slrf_pkg::V_W'(slrf_pkg::CO_LO * 256)) begin
            v_clamp = slrf_pkg::V_W'(slrf_pkg::CO_LO * 256);
        end else if (v_mod > slrf_pkg::V_W'(slrf_pkg::CO_HI * 256)) begin
            v_clamp = slrf_pkg::V_W'(slrf_pkg::CO_HI * 256);
        end else begin
            v_clamp = v_mod;
        end
        v_round = $unsigned(v_clamp) + slrf_pkg::V_W'(128);
        co_new  = v_round[slrf_pkg::CO_W+7:8];
        fa_new  = (slrf_pkg::CO_W'(1) << F) - co_new;
    end

    assign rem_sh = {r_rem, r_dnum[slrf_pkg::DIV_W-1]};
    assign q_bit  = rem_sh >= (F+1)'(r_fa);

    // Rounded, saturated magnitude of the product, then the signed sum.
    always_comb begin
        mq_sum = (SUM_W'(r_prod[HP_W-1:0]) << 32) + SUM_W'(r_plo);
        mq_rnd = (mq_sum + (SUM_W'(1) << (F - 1))) >> F;
        if (mq_rnd > SUM_W'(slrf_pkg::STATE_MAX)) begin
            mq_mag = SW'(slrf_pkg::STATE_MAX);
        end else begin
            mq_mag = mq_rnd[SW-1:0];
        end
        mq = r_neg ? -$signed({1'b0, mq_mag}) : $signed({1'b0, mq_mag});
        if (r_op == OP_FEED) begin
            acc_sum = (SW+2)'(r_x) + (SW+2)'(mq);
        end else begin
            acc_sum = (SW+2)'(r_t) + (SW+2)'(mq);
        end
    end

    always_comb begin
        if (i_cfg.mode) begin
            y = (SW+1)'(r_x) - (SW+1)'(r_s2);
        end else begin
            y = (SW+1)'(r_s2);
        end
        y_rnd  = (SW+2)'(y) + (SW+2)'(1 << (F - 1));
        o_full = y_rnd >>> F;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_FEED;
            r_cnt   <= '0;
            r_co    <= '0;
            r_fa    <= '0;
            r_fb    <= '0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_prod <= m_a * m_b;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= {{(SW-SMW-1-F){smp1[SMW]}}, smp1, {F{1'b0}}};
                        r_phase <= i_phase;
                        r_op    <= OP_FEED;
                        r_state <= i_block_start ? S_ROM : S_ABS;
                    end
                end
                S_ROM: begin
                    r_sine  <= slrf_pkg::SINE_ROM[r_phase[slrf_pkg::PHASE_W-1 -:
                                                          slrf_pkg::SINE_AW]];
                    r_state <= S_SMUL;
                end
                S_SMUL: begin
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_co    <= co_new;
                    r_fa    <= fa_new;
                    r_rem   <= '0;
                    r_dnum  <= (slrf_pkg::DIV_W'(1) << (2 * F))
                             + slrf_pkg::DIV_W'(fa_new >> 1);
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= q_bit ? F'(rem_sh - (F+1)'(r_fa)) : rem_sh[F-1:0];
                    r_dnum <= r_dnum << 1;
                    r_quo  <= {r_quo[slrf_pkg::RECIP_W-2:0], q_bit};
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(slrf_pkg::DIV_W - 1)) begin
                        r_state <= S_FBMUL;
                    end
                end
                S_FBMUL: begin
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_fb    <= slrf_pkg::FB_W'((r_prod + slrf_pkg::P_W'(128)) >> 8);
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_ua    <= op_a[SW] ? $unsigned(-op_a) : $unsigned(op_a);
                    r_neg   <= op_a[SW];
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_plo   <= r_prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_state <= S_ABS;
                    r_op    <= r_op + 3'd1;
                    unique case (r_op)
                        OP_FEED: r_u <= slrf_pkg::sat_state(acc_sum);
                        OP_S1FA: r_t <= mq[SW-1:0];
                        OP_UCO:  r_a <= slrf_pkg::sat_state(acc_sum);
                        OP_S2FA: r_t <= mq[SW-1:0];
                        default: begin
                            r_s1    <= r_a;
                            r_s2    <= slrf_pkg::sat_state(acc_sum);
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    if (o_full > (SW+2)'((1 << (SMW - 1)) - 1)) begin
                        r_out <= SMW'((1 << (SMW - 1)) - 1);
                    end else if (o_full < -(SW+2)'(1 << (SMW - 1))) begin
                        r_out <= SMW'(1 << (SMW - 1));
                    end else begin
                        r_out <= o_full[SMW-1:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

// ----- hw/rtl/stereo_lfo_resonant_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_lfo_resonant_filter_unit
// Stereo two-pole resonant low/high-pass filter with a sine LFO on cutoff.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one stereo sample pair per beat; tuser flags a block
//   start, which refreshes both channels' coefficients from the current LFO
//   phase before that pair is filtered. m_axis returns one filtered pair for
//   every input beat, in order.
//   The two channel lanes run in lockstep on one item at a time, each on its
//   own shared multiplier. A block-start pair first runs the 33-step
//   reciprocal divider for its new coefficients. The next pair is taken as
//   soon as the previous result has moved into the output register.
//   If the receiver stalls, the finished result waits in the output register
//   and one more pair may be taken and processed; its result then waits in
//   the lane until the output register frees up.
//   Reset clears the filter state, the LFO phase and the coefficients (all zero until
//   the first block start) and loads the register defaults: cutoff 128, everything
//   else 0. The user must write registers only while idle; the block does not check it.
// ----------------------------------------------------------------------------
module stereo_lfo_resonant_filter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [slrf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [slrf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,  // left_sample, right_sample
    input  logic [0:0]                          s_axis_tuser,  // block_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata   // left_out, right_out
);

    localparam int SMW = slrf_pkg::SAMPLE_W;
    localparam int PW  = slrf_pkg::PHASE_W;

    logic [7:0]           r_cutoff;
    logic [7:0]           r_resonance;
    logic [15:0]          r_rate;
    logic [7:0]           r_depth;
    logic [7:0]           r_ofs;
    logic                 r_mode;
    logic [PW-1:0]        r_phase;
    logic                 r_busy;
    logic                 r_pend;
    logic                 r_mvalid;
    logic [2*SMW-1:0]     r_mdata;

    slrf_pkg::t_lane_cfg  cfg_l;
    logic                 accept;
    logic                 pend;
    logic                 load;
    logic [47:0]          step_full;
    logic [PW-1:0]        phase_r;
    logic                 l_done;
    logic                 rt_done;
    logic signed [SMW-1:0] l_out;
    logic signed [SMW-1:0] rt_out;

    assign cfg_l = '{cutoff: r_cutoff, resonance: r_resonance,
                     depth: r_depth, mode: r_mode};
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign step_full = 48'(r_rate) * 48'(slrf_pkg::STEP_MUL) + 48'(32768);
    assign phase_r   = r_phase + (PW'(r_ofs) << (PW - 9));

    slrf_lane u_left (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept),
        .i_block_start (s_axis_tuser[0]),
        .i_sample      (s_axis_tdata[SMW-1:0]),
        .i_phase       (r_phase),
        .i_cfg         (cfg_l),
        .o_done        (l_done),
        .o_out         (l_out)
    );

    slrf_lane u_right (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept),
        .i_block_start (s_axis_tuser[0]),
        .i_sample      (s_axis_tdata[2*SMW-1:SMW]),
        .i_phase       (phase_r),
        .i_cfg         (cfg_l),
        .o_done        (rt_done),
        .o_out         (rt_out)
    );

    // Merge the lanes into the output register once it is free.
    assign pend = l_done || r_pend;
    assign load = pend && (!r_mvalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff    <= 8'd128;
            r_resonance <= '0;
            r_rate      <= '0;
            r_depth     <= '0;
            r_ofs       <= '0;
            r_mode      <= 1'b0;
            r_phase     <= '0;
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_mvalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    slrf_pkg::REG_CUTOFF:    r_cutoff    <= i_cfg_data[7:0];
                    slrf_pkg::REG_RESONANCE: r_resonance <= i_cfg_data[7:0];
                    slrf_pkg::REG_LFO_RATE:  r_rate      <= i_cfg_data[15:0];
                    slrf_pkg::REG_LFO_DEPTH: r_depth     <= i_cfg_data[7:0];
                    slrf_pkg::REG_LFO_OFS:   r_ofs       <= i_cfg_data[7:0];
                    slrf_pkg::REG_MODE:      r_mode      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_busy  <= 1'b1;
                r_phase <= r_phase + step_full[PW+15:16];
            end else if (load) begin
                r_busy <= 1'b0;
            end
            r_pend <= pend && !load;
            if (load) begin
                r_mvalid <= 1'b1;
                r_mdata  <= {rt_out, l_out};
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    assign s_axis_tready = !r_busy;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

`ifndef SYNTHESIS
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        l_done == rt_done)
        else $error("channel lanes finished in different cycles");

    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        l_done |-> r_busy)
        else $error("lane finished with no item in flight");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_phase))
        else $error("LFO phase moved without an input beat");

    a_load_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> r_busy)
        else $error("output loaded with no item in flight");
`endif

endmodule
